>>> src/tcc_pkg.sv
package tcc_pkg;

   typedef enum logic [1:0] {
      KIND_START = 2'd0,
      KIND_POINT = 2'd1,
      KIND_AFFINE = 2'd2,
      KIND_NONE = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ROW_CONST = 2'd0,
      ROW_BLUE = 2'd1,
      ROW_GREEN = 2'd2,
      ROW_RED = 2'd3
   } row_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_SUM,
      ST_LOG,
      ST_ULG,
      ST_ULN,
      ST_WMUL,
      ST_ACC,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic sqr;
      logic sum;
      logic lg;
      logic ulg;
      logic uln;
      logic wmul;
      logic acc;
      logic fin;
      logic out_load;
   } cmd_type;

   localparam int unsigned LN2_Q16 = 45426;
   localparam int S_W = 18;
   localparam int P_W = 5;

   // log2(1 + i/2^tb) in q16 by repeated squaring in q30
   function automatic logic [15:0] mant_log2(input int unsigned idx, input int tb);
      logic [63:0] m;
      logic [15:0] res;
      m = (64'(1 << tb) + 64'(idx)) << (30 - tb);
      res = '0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         res = {res[14:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            res[0] = 1'b1;
            m = m >> 1;
         end
      end
      return res;
   endfunction

endpackage

>>> src/tcc_if.sv
interface tcc_req_if;
   import tcc_pkg::*;
   logic valid;
   logic ready;
   logic [1:0] kind;
   logic [7:0] color_b;
   logic [7:0] color_g;
   logic [7:0] color_r;
   logic signed [31:0] weight_b;
   logic signed [31:0] weight_g;
   logic signed [31:0] weight_r;
   logic [1:0] affine_row;
   modport source (output valid, kind, color_b, color_g, color_r, weight_b, weight_g,
      weight_r, affine_row, input ready);
   modport sink (input valid, kind, color_b, color_g, color_r, weight_b, weight_g,
      weight_r, affine_row, output ready);
endinterface

interface tcc_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] out_b;
   logic [7:0] out_g;
   logic [7:0] out_r;
   logic clipped;
   modport source (output valid, out_b, out_g, out_r, clipped, input ready);
   modport sink (input valid, out_b, out_g, out_r, clipped, output ready);
endinterface

>>> src/tcc_ctrl.sv
module tcc_ctrl
   import tcc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [1:0] req_kind,
   input  logic [1:0] req_affine_row,
   input  logic rsp_valid,
   input  logic rsp_ready,
   output cmd_type cmd
);
   state_type state_ff, state_in;
   logic fire;

   // results leave through the output register; wait only if it is still full at finish
   assign req_ready = (state_ff == ST_IDLE);
   assign fire = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (fire) begin
               priority case (kind_type'(req_kind))
                  KIND_POINT: state_in = ST_DIST;
                  KIND_AFFINE: state_in = ST_WMUL;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIST: state_in = ST_SUM;
         ST_SUM: state_in = ST_LOG;
         ST_LOG: state_in = ST_ULG;
         ST_ULG: state_in = ST_ULN;
         ST_ULN: state_in = ST_WMUL;
         ST_WMUL: state_in = ST_ACC;
         ST_ACC: state_in = ST_FIN;
         ST_FIN: state_in = ST_OUT;
         ST_OUT: if (!rsp_valid || rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: cmd.load = fire;
         ST_DIST: cmd.sqr = 1'b1;
         ST_SUM: cmd.sum = 1'b1;
         ST_LOG: cmd.lg = 1'b1;
         ST_ULG: cmd.ulg = 1'b1;
         ST_ULN: cmd.uln = 1'b1;
         ST_WMUL: cmd.wmul = 1'b1;
         ST_ACC: cmd.acc = 1'b1;
         ST_FIN: cmd.fin = 1'b1;
         ST_OUT: cmd.out_load = !rsp_valid || rsp_ready;
         default: cmd = '0;
      endcase
   end

   // after accumulate, only the finishing affine row continues to output
   state_type state_gated;
   logic is_last_ff, is_last_in;
   always_comb begin
      is_last_in = is_last_ff;
      if (fire) is_last_in = (req_kind == KIND_AFFINE) && (req_affine_row == ROW_RED);
   end

   always_comb begin
      state_gated = state_in;
      if (state_ff == ST_ACC && !is_last_ff) state_gated = ST_IDLE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         is_last_ff <= 1'b0;
      end else begin
         state_ff <= state_gated;
         is_last_ff <= is_last_in;
      end
   end
endmodule

>>> src/tcc_datapath.sv
module tcc_datapath
   import tcc_pkg::*;
#(
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int LOG_TABLE_BITS = 8
)(
   input  logic clock,
   input  logic reset,
   input  cmd_type cmd,
   input  logic [1:0] req_kind,
   input  logic [7:0] req_color_b,
   input  logic [7:0] req_color_g,
   input  logic [7:0] req_color_r,
   input  logic signed [31:0] req_weight_b,
   input  logic signed [31:0] req_weight_g,
   input  logic signed [31:0] req_weight_r,
   input  logic [1:0] req_affine_row,
   input  logic rsp_ready,
   output logic rsp_valid,
   output logic [7:0] rsp_out_b,
   output logic [7:0] rsp_out_g,
   output logic [7:0] rsp_out_r,
   output logic rsp_clipped
);
   localparam int ACC_FRAC = WEIGHT_FRAC_BITS + 8;
   localparam int TB = LOG_TABLE_BITS;
   localparam int NT = 1 << TB;
   localparam int LG_W = P_W + 16;

   logic [7:0] pix_b_ff, pix_g_ff, pix_r_ff, col_b_ff, col_g_ff, col_r_ff;
   logic signed [31:0] w_b_ff, w_g_ff, w_r_ff;
   logic kind_aff_ff;
   logic [1:0] row_ff;
   logic [63:0] acc_b_ff, acc_g_ff, acc_r_ff;
   logic [15:0] sq_b_ff, sq_g_ff, sq_r_ff;
   logic [S_W-1:0] s_ff;
   logic [LG_W-1:0] lg_ff;
   logic [S_W+LG_W-1:0] slg_ff;
   logic [32:0] u_ff;
   logic [63:0] p_b_ff, p_g_ff, p_r_ff;
   logic [7:0] ob_ff, og_ff, or_ff;
   logic clip_ff, rv_ff;

   function automatic logic signed [8:0] sdiff(input logic [7:0] a, input logic [7:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   logic signed [8:0] db, dg, dr;
   assign db = sdiff(pix_b_ff, col_b_ff);
   assign dg = sdiff(pix_g_ff, col_g_ff);
   assign dr = sdiff(pix_r_ff, col_r_ff);

   // leading one and mantissa index
   logic [P_W-1:0] lead;
   logic [TB-1:0] idx;
   logic [S_W+TB-1:0] sx;
   always_comb begin
      lead = '0;
      for (int i = 0; i < S_W; i++)
         if (s_ff[i]) lead = P_W'(i);
      sx = {s_ff, {TB{1'b0}}} >> lead;
      idx = sx[TB-1:0];
   end

   logic [15:0] mant [NT];
   for (genvar g = 0; g < NT; g++) begin : g_tab
      assign mant[g] = mant_log2(g, TB);
   end

   logic signed [33:0] mult_in;
   logic [8:0] aff_c;
   always_comb begin
      priority case (row_type'(row_ff))
         ROW_BLUE: aff_c = {1'b0, pix_b_ff};
         ROW_GREEN: aff_c = {1'b0, pix_g_ff};
         ROW_RED: aff_c = {1'b0, pix_r_ff};
         default: aff_c = 9'd1;
      endcase
      mult_in = kind_aff_ff ? 34'({aff_c, 8'd0}) : 34'(u_ff);
   end

   function automatic logic [8:0] fin(input logic [63:0] acc, output logic clip);
      logic [63:0] a, q, bias;
      a = acc ^ 64'h8000_0000_0000_0000;
      bias = 64'd1 << (63 - ACC_FRAC);
      q = (a >> ACC_FRAC) + 64'((a >> (ACC_FRAC - 1)) & 64'd1);
      clip = 1'b0;
      if (q < bias) begin
         clip = 1'b1;
         return 9'd0;
      end
      q = q - bias;
      if (q > 64'd255) begin
         clip = 1'b1;
         return 9'd255;
      end
      return {1'b0, q[7:0]};
   endfunction

   logic [8:0] fb, fg, fr;
   logic cb, cg, cr;
   always_comb begin
      fb = fin(acc_b_ff, cb);
      fg = fin(acc_g_ff, cg);
      fr = fin(acc_r_ff, cr);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_b_ff <= req_color_b;
         col_g_ff <= req_color_g;
         col_r_ff <= req_color_r;
         w_b_ff <= req_weight_b;
         w_g_ff <= req_weight_g;
         w_r_ff <= req_weight_r;
         row_ff <= req_affine_row;
         kind_aff_ff <= (req_kind == KIND_AFFINE);
      end
      if (cmd.sqr) begin
         sq_b_ff <= 16'(db * db);
         sq_g_ff <= 16'(dg * dg);
         sq_r_ff <= 16'(dr * dr);
      end
      if (cmd.sum) s_ff <= S_W'(sq_b_ff) + S_W'(sq_g_ff) + S_W'(sq_r_ff);
      if (cmd.lg) lg_ff <= {lead, 16'd0} + LG_W'(mant[idx]);
      if (cmd.ulg) slg_ff <= (S_W+LG_W)'(s_ff * lg_ff);
      if (cmd.uln) u_ff <= 33'((64'(slg_ff) * 64'(LN2_Q16)) >> 25);
      if (cmd.wmul) begin
         p_b_ff <= 64'($signed(w_b_ff) * mult_in);
         p_g_ff <= 64'($signed(w_g_ff) * mult_in);
         p_r_ff <= 64'($signed(w_r_ff) * mult_in);
      end
      if (cmd.fin) begin
         ob_ff <= fb[7:0];
         og_ff <= fg[7:0];
         or_ff <= fr[7:0];
         clip_ff <= cb | cg | cr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_b_ff <= '0;
         pix_g_ff <= '0;
         pix_r_ff <= '0;
         acc_b_ff <= '0;
         acc_g_ff <= '0;
         acc_r_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         if (cmd.load && req_kind == KIND_START) begin
            pix_b_ff <= req_color_b;
            pix_g_ff <= req_color_g;
            pix_r_ff <= req_color_r;
            acc_b_ff <= '0;
            acc_g_ff <= '0;
            acc_r_ff <= '0;
         end
         if (cmd.acc) begin
            acc_b_ff <= acc_b_ff + p_b_ff;
            acc_g_ff <= acc_g_ff + p_g_ff;
            acc_r_ff <= acc_r_ff + p_r_ff;
         end
         if (cmd.out_load) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
      end
   end

   logic [7:0] rb_ff, rg_ff, rr_ff;
   logic rc_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rb_ff <= ob_ff;
         rg_ff <= og_ff;
         rr_ff <= or_ff;
         rc_ff <= clip_ff;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_out_b = rb_ff;
   assign rsp_out_g = rg_ff;
   assign rsp_out_r = rr_ff;
   assign rsp_clipped = rc_ff;
endmodule

>>> src/tps_color_compensate_pixel.sv
// Thin plate spline colour map for one pixel. A start item latches the pixel and clears
// the sums, control-point items add weight times s*ln(s)/2, affine rows add the linear
// terms, and affine row 3 yields one rounded, saturated result with a clip flag.
// Start and unused items end where they are accepted; affine rows pass the weight multiply
// and the accumulate, row 3 then the finish and the output register (held while an earlier
// result still waits); control points step through the squares, the sum, leading-one log
// lookup, two products, the weight multiply and the accumulate. Items are taken one at a time.
module tps_color_compensate_pixel
   import tcc_pkg::*;
#(
   parameter int WEIGHT_FRAC_BITS = 16,
   parameter int LOG_TABLE_BITS = 8
)(
   input logic clock,
   input logic reset,
   tcc_req_if.sink req,
   tcc_rsp_if.source rsp
);
   cmd_type cmd;

   tcc_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .req_kind(req.kind), .req_affine_row(req.affine_row),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd)
   );

   tcc_datapath #(
      .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)
   ) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_kind(req.kind), .req_color_b(req.color_b), .req_color_g(req.color_g),
      .req_color_r(req.color_r), .req_weight_b(req.weight_b),
      .req_weight_g(req.weight_g), .req_weight_r(req.weight_r),
      .req_affine_row(req.affine_row), .rsp_ready(rsp.ready),
      .rsp_valid(rsp.valid), .rsp_out_b(rsp.out_b), .rsp_out_g(rsp.out_g),
      .rsp_out_r(rsp.out_r), .rsp_clipped(rsp.clipped)
   );

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one datapath command");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.sqr |=> !req.ready) else $error("accepting while busy");
   a_out_after_fin: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> $past(cmd.fin) || $past(cmd.out_load) || !$past(rsp.ready))
      else $error("output load without finish");
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import tcc_pkg::*;

   localparam int FRAC = 16;
   localparam int TBITS = 8;
   localparam int ACC_FRAC = FRAC + 8;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct packed {
      logic [7:0] b;
      logic [7:0] g;
      logic [7:0] r;
      logic clip;
   } pixel_out_type;

   typedef struct {
      kind_type kind;
      logic [7:0] cb, cg, cr;
      logic signed [31:0] wb, wg, wr;
      row_type row;
      logic check;
      pixel_out_type want;
   } stim_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   tcc_req_if req ();
   tcc_rsp_if rsp ();

   tps_color_compensate_pixel DUT (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic [7:0] pix_b, pix_g, pix_r;
   logic [63:0] sum_b, sum_g, sum_r;
   pixel_out_type pending_q[$];
   int errors = 0;
   int cycles = 0;
   int send_idle = 12, recv_idle = 48;
   logic hold_off = 1'b0;
   stim_type directed[$];

   function automatic logic [15:0] mantissa_log(input logic [TBITS-1:0] idx);
      logic [63:0] m;
      logic [15:0] res;
      m = (64'(1 << TBITS) + 64'(idx)) << (30 - TBITS);
      res = '0;
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         res = {res[14:0], 1'b0};
         if (m >= 64'h8000_0000) begin
            res[0] = 1'b1;
            m = m >> 1;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] spline_energy(input logic [63:0] s);
      int p;
      logic [63:0] idx, lg;
      if (s == 0) return 0;
      p = 0;
      while ((s >> (p + 1)) != 0) p++;
      if (p >= TBITS) idx = (s >> (p - TBITS)) & ((1 << TBITS) - 1);
      else idx = (s << (TBITS - p)) & ((1 << TBITS) - 1);
      lg = (64'(p) << 16) + 64'(mantissa_log(idx[TBITS-1:0]));
      return (s * lg * 64'(LN2_Q16)) >> 25;
   endfunction

   function automatic logic [7:0] round_sat(input logic [63:0] acc, inout logic clip);
      logic [63:0] a, q, bias;
      a = acc ^ (64'd1 << 63);
      bias = 64'd1 << (63 - ACC_FRAC);
      q = (a >> ACC_FRAC) + ((a >> (ACC_FRAC - 1)) & 64'd1);
      if (q < bias) begin
         clip = 1'b1;
         return 8'd0;
      end
      q = q - bias;
      if (q > 255) begin
         clip = 1'b1;
         return 8'd255;
      end
      return q[7:0];
   endfunction

   task automatic predict_pixel(input stim_type it, output logic emit,
         output pixel_out_type res);
      logic signed [63:0] db, dg, dr, u, c;
      emit = 1'b0;
      res = '0;
      case (it.kind)
         KIND_START: begin
            pix_b = it.cb;
            pix_g = it.cg;
            pix_r = it.cr;
            sum_b = 0;
            sum_g = 0;
            sum_r = 0;
         end
         KIND_POINT: begin
            db = $signed({56'd0, pix_b}) - $signed({56'd0, it.cb});
            dg = $signed({56'd0, pix_g}) - $signed({56'd0, it.cg});
            dr = $signed({56'd0, pix_r}) - $signed({56'd0, it.cr});
            u = $signed(spline_energy(db * db + dg * dg + dr * dr));
            sum_b += 64'(64'(it.wb) * u);
            sum_g += 64'(64'(it.wg) * u);
            sum_r += 64'(64'(it.wr) * u);
         end
         KIND_AFFINE: begin
            case (it.row)
               ROW_BLUE: c = {56'd0, pix_b};
               ROW_GREEN: c = {56'd0, pix_g};
               ROW_RED: c = {56'd0, pix_r};
               default: c = 1;
            endcase
            sum_b += 64'(64'(it.wb) * c) << 8;
            sum_g += 64'(64'(it.wg) * c) << 8;
            sum_r += 64'(64'(it.wr) * c) << 8;
            if (it.row == ROW_RED) begin
               emit = 1'b1;
               res.clip = 1'b0;
               res.b = round_sat(sum_b, res.clip);
               res.g = round_sat(sum_g, res.clip);
               res.r = round_sat(sum_r, res.clip);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send(input stim_type it);
      logic emit;
      pixel_out_type res;
      while ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.kind <= it.kind;
      req.color_b <= it.cb;
      req.color_g <= it.cg;
      req.color_r <= it.cr;
      req.weight_b <= it.wb;
      req.weight_g <= it.wg;
      req.weight_r <= it.wr;
      req.affine_row <= it.row;
      do @(posedge clock); while (!req.ready);
      predict_pixel(it, emit, res);
      if (emit) begin
         if (it.check && res != it.want) begin
            $error("table row: expected %h got predictor %h", it.want, res);
            errors++;
         end
         pending_q = {pending_q, (it.check ? it.want : res)};
      end
      @(negedge clock);
   endtask

   task automatic bus_idle();
      req.valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic stim_type mk(kind_type k, int cb, int cg, int cr,
         int wb, int wg, int wr, row_type row);
      stim_type it;
      it.kind = k;
      it.cb = 8'(cb);
      it.cg = 8'(cg);
      it.cr = 8'(cr);
      it.wb = wb;
      it.wg = wg;
      it.wr = wr;
      it.row = row;
      it.check = 1'b0;
      it.want = '0;
      return it;
   endfunction

   function automatic logic [31:0] rand_weight();
      case ($urandom_range(5))
         0: return $urandom;
         1: return 32'h8000_0000 | $urandom_range(3);
         2: return 32'h7fff_fff0 | $urandom_range(15);
         default: return 32'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   function automatic stim_type rand_item(kind_type k, row_type row);
      return mk(k, $urandom_range(255), $urandom_range(255), $urandom_range(255),
         rand_weight(), rand_weight(), rand_weight(), row);
   endfunction

   task automatic random_phase(input int n);
      int sent;
      sent = 0;
      while (sent < n) begin
         if ($urandom_range(9) < 8) begin
            send(rand_item(KIND_START, ROW_CONST));
            repeat ($urandom_range(4)) send(rand_item(KIND_POINT, ROW_CONST));
            send(rand_item(KIND_AFFINE, ROW_CONST));
            send(rand_item(KIND_AFFINE, ROW_BLUE));
            send(rand_item(KIND_AFFINE, ROW_GREEN));
            send(rand_item(KIND_AFFINE, ROW_RED));
            sent += 7;
         end else begin
            send(rand_item(kind_type'($urandom_range(3)), row_type'($urandom_range(3))));
            sent++;
         end
      end
      bus_idle();
   endtask

   // result side
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_q.size() == 0) begin
            $error("unexpected transfer %h", {rsp.out_b, rsp.out_g, rsp.out_r, rsp.clipped});
            errors++;
         end else begin
            pixel_out_type w;
            w = pending_q.pop_front();
            if (rsp.out_b !== w.b) begin
               $error("out_b expected %0d actual %0d", w.b, rsp.out_b);
               errors++;
            end
            if (rsp.out_g !== w.g) begin
               $error("out_g expected %0d actual %0d", w.g, rsp.out_g);
               errors++;
            end
            if (rsp.out_r !== w.r) begin
               $error("out_r expected %0d actual %0d", w.r, rsp.out_r);
               errors++;
            end
            if (rsp.clipped !== w.clip) begin
               $error("clipped expected %0d actual %0d", w.clip, rsp.clipped);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tps_color_compensate_pixel verification failed");
         $finish;
      end
   end

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_NONE;
      req.color_b = '0;
      req.color_g = '0;
      req.color_r = '0;
      req.weight_b = '0;
      req.weight_g = '0;
      req.weight_r = '0;
      req.affine_row = ROW_CONST;
      rsp.ready = 1'b0;
      pix_b = 0; pix_g = 0; pix_r = 0;
      sum_b = 0; sum_g = 0; sum_r = 0;

      // no start after reset: zero sums give zero, no clip
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 0, 0, 0, ROW_RED)};
      directed[$].check = 1'b1;
      directed = {directed, mk(KIND_NONE, 255, 255, 255, -1, -1, -1, ROW_RED)};
      // constant 128 on each channel
      directed = {directed, mk(KIND_START, 255, 0, 128, 0, 0, 0, ROW_CONST)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 128 << FRAC, 128 << FRAC,
         128 << FRAC, ROW_CONST)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 0, 0, 0, ROW_RED)};
      directed[$].check = 1'b1;
      directed[$].want = {8'd128, 8'd128, 8'd128, 1'b0};
      // saturation both ways
      directed = {directed, mk(KIND_START, 255, 255, 255, 0, 0, 0, ROW_CONST)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 32'h7fffffff, 32'h80000000, 0,
         ROW_BLUE)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 0, 0, 0, ROW_RED)};
      directed[$].check = 1'b1;
      directed[$].want = {8'd255, 8'd0, 8'd0, 1'b1};
      // identity affine map and extreme control points
      directed = {directed, mk(KIND_START, 255, 0, 77, 0, 0, 0, ROW_CONST)};
      directed = {directed, mk(KIND_POINT, 255, 0, 77, 32'h7fffffff, 1, -1, ROW_CONST)};
      directed = {directed, mk(KIND_POINT, 0, 255, 0, 1, -1, 3, ROW_CONST)};
      directed = {directed, mk(KIND_POINT, 254, 0, 77, 32'h80000000, 32'h7fffffff, 5,
         ROW_CONST)};
      directed = {directed, mk(KIND_POINT, 0, 255, 255, -3, 2, 32'h80000000, ROW_CONST)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 1 << FRAC, 0, 0, ROW_BLUE)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 0, 1 << FRAC, 0, ROW_GREEN)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 0, 0, 1 << FRAC, ROW_RED)};
      directed = {directed, mk(KIND_START, 10, 20, 30, 0, 0, 0, ROW_CONST)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 1 << FRAC, 1 << FRAC, 1 << FRAC,
         ROW_BLUE)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 1 << FRAC, 1 << FRAC, 1 << FRAC,
         ROW_GREEN)};
      directed = {directed, mk(KIND_AFFINE, 0, 0, 0, 32'h00008000, 32'h00007fff, 0,
         ROW_RED)};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send(directed[i]);

      random_phase(400);
      // long receiver hold-off while input keeps coming
      hold_off = 1'b1;
      fork
         begin
            int n;
            n = 0;
            while (n < 400) begin
               @(posedge clock);
               n++;
            end
            hold_off = 1'b0;
         end
         random_phase(40);
      join
      @(negedge clock);
      send_idle = 48;
      recv_idle = 12;
      random_phase(400);
      send_idle = 0;
      recv_idle = 0;
      random_phase(400);

      while (pending_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tps_color_compensate_pixel verification clean");
      end else begin
         $display("tps_color_compensate_pixel verification failed");
      end
      $finish;
   end
endmodule
